@@ design/hfcu_pkg.sv @@
// Package with types, constants and conversion functions for the half/single conversion unit.
package hfcu_pkg;

  typedef enum logic {
    CMD_S2H = 1'b0,
    CMD_H2S = 1'b1
  } cmd_e;

  localparam logic [15:0] HALF_INF  = 16'h7C00;
  localparam logic [15:0] HALF_NAN  = 16'h7FFF;
  localparam logic [31:0] SGL_INF   = 32'h7F800000;
  localparam logic [31:0] SGL_QNAN  = 32'h7FC00000;

  // Single to half: truncating, flushes small values to signed zero.
  function automatic logic [15:0] single_to_half(input logic [31:0] x);
    logic [7:0]  e;
    logic [22:0] m;
    logic [15:0] s;
    logic [7:0]  eh;
    logic [15:0] r;
    e  = x[30:23];
    m  = x[22:0];
    s  = {x[31], 15'd0};
    eh = e - 8'd112;
    if (e == 8'd255) begin
      r = s | ((m == 23'd0) ? HALF_INF : HALF_NAN);
    end else if (e > 8'd142) begin
      r = s | HALF_INF;
    end else if (e <= 8'd112) begin
      r = s;
    end else begin
      r = {x[31], eh[4:0], m[22:13]};
    end
    return r;
  endfunction

  // Half to single: exact, subnormals normalized by a leading-one search.
  function automatic logic [31:0] half_to_single(input logic [15:0] x);
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  p;
    logic [22:0] fm;
    logic [7:0]  se;
    logic [31:0] r;
    e = x[14:10];
    m = x[9:0];
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) p = 4'(i);
    end
    fm = 23'({m, 13'd0} << (4'd10 - p));
    se = 8'(p) + 8'd103;
    if (e == 5'd0) begin
      if (m == 10'd0) r = {x[15], 31'd0};
      else            r = {x[15], se, fm};
    end else if (e == 5'd31) begin
      r = {x[15], 31'd0} | ((m == 10'd0) ? SGL_INF : SGL_QNAN);
    end else begin
      r = {x[15], 8'(e) + 8'd112, m, 13'd0};
    end
    return r;
  endfunction

endpackage

@@ design/hfcu_core.sv @@
// Combinational conversion datapath between the input and result registers.
module hfcu_core
  import hfcu_pkg::*;
(
  input  logic        command_i,
  input  logic [31:0] operand_bits_i,
  output logic [31:0] result_bits_o
);

  always_comb begin
    if (cmd_e'(command_i) == CMD_H2S) begin
      result_bits_o = half_to_single(operand_bits_i[15:0]);
    end else begin
      result_bits_o = {16'd0, single_to_half(operand_bits_i)};
    end
  end

endmodule

@@ design/half_float_conversion_unit.sv @@
// Top level of the half/single floating-point conversion unit.
// The unit converts one operand per transfer. The input channel carries
// command_i (0 converts a single to a half, 1 a half to a single) and
// operand_bits_i; a transfer happens at a clock edge with in_valid_i high
// and in_stall_o low. Each input transfer yields exactly one result on the
// output channel, result_bits_o, qualified by out_valid_o and held while
// out_stall_i is high.
// The operand is captured in an input register, converted by shallow
// combinational logic, and written into the result register when that
// register is empty or being drained. A result passes through the input
// register and then the result register. One item per cycle is sustained
// when the receiver does not stall.
// When the receiver stalls, the result register holds its value and the
// input register holds its item; the input side stalls only when both are
// full. Reset clears all valid flags, so no result is shown after reset.
module half_float_conversion_unit
  import hfcu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [31:0] operand_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_bits_o
);

  logic        in_vld_q;
  logic        in_cmd_q;
  logic [31:0] in_op_q;
  logic        out_vld_q;
  logic [31:0] out_res_q;
  logic [31:0] conv_res;
  logic        out_load;
  logic        in_load;

  hfcu_core u_core (
    .command_i      (in_cmd_q),
    .operand_bits_i (in_op_q),
    .result_bits_o  (conv_res)
  );

  // The result stage takes a new value when it is empty or being drained.
  assign out_load   = !out_vld_q || !out_stall_i;
  assign in_load    = !in_vld_q || out_load;
  assign in_stall_o = !in_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_load) in_vld_q <= in_valid_i;
      if (out_load) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      in_cmd_q <= command_i;
      in_op_q  <= operand_bits_i;
    end
    if (out_load && in_vld_q) begin
      out_res_q <= conv_res;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign result_bits_o = out_res_q;

  // A stalled result must stay valid with its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> out_vld_q && $stable(out_res_q))
    else $error("stalled result lost");

  // The input only stalls when both stages hold items.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && out_vld_q)
    else $error("needless input stall");

  // A half result always has its upper half cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && in_vld_q && !in_cmd_q |=> out_res_q[31:16] == 16'd0)
    else $error("half result upper bits set");

endmodule
